// File: design/wmrp_pkg.sv
// Types and constants for the write-multiple-registers request parser.
package wmrp_pkg;

	localparam logic [7:0]  FUNC_CODE = 8'h10;
	localparam logic [15:0] MIN_QTY   = 16'h0001;
	localparam logic [15:0] MAX_REGS  = 16'd123;

	// data bytes counter stops here, above any byte count
	localparam logic [8:0]  DATA_SAT  = 9'd256;

	localparam logic [2:0] ST_OK        = 3'd0;
	localparam logic [2:0] ST_SHORT     = 3'd1;
	localparam logic [2:0] ST_BAD_CODE  = 3'd2;
	localparam logic [2:0] ST_BAD_QTY   = 3'd3;
	localparam logic [2:0] ST_COUNT_ERR = 3'd4;
	localparam logic [2:0] ST_LEN_ERR   = 3'd5;

	// header byte expected next; POS_DATA once the six header bytes are in
	typedef enum logic [2:0] {
		POS_CODE,
		POS_ADDR_HI,
		POS_ADDR_LO,
		POS_QTY_HI,
		POS_QTY_LO,
		POS_COUNT,
		POS_DATA
	} hdr_pos_t;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       frame_end;
	} req_t;

	typedef struct packed {
		logic        is_verdict;
		logic [15:0] start_address;
		logic [6:0]  value_index;
		logic [15:0] reg_value;
		logic [2:0]  status;
		logic        last_of_run;
	} res_t;

endpackage

// File: design/write_multiple_registers_parser_top.sv
// Write-multiple-registers request parser: header capture, value assembly, verdict.
//
//  channel | signals                    | payload | item
//  --------+----------------------------+---------+---------------------------------
//  req     | req_valid, req_ready, req  | req_t   | one PDU byte, end-of-frame flag
//  res     | res_valid, res_ready, res  | res_t   | one register value or a verdict
//
// One byte per cycle: a byte is held in the input register, then its
// results go into a two-entry result queue. A frame's last byte that also
// completes a value makes two results; the queue takes both, and the byte
// after it is a header byte with at most one result, so a consumer taking
// one result a cycle never holds the input. Reset clears the header state,
// the counters and the queue. A stalled consumer stalls the input once the
// queue cannot take the next byte's results.
module write_multiple_registers_parser_top
	import wmrp_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_ready,
	input  req_t req,
	output logic res_valid,
	input  logic res_ready,
	output res_t res
);

	// input register
	logic v_s1;
	req_t req_s1;

	// parser state
	hdr_pos_t    pos_q, pos_n;
	logic        code_ok_q, code_ok_n;
	logic [15:0] addr_q, addr_n;
	logic [15:0] qty_q, qty_n;
	logic [7:0]  count_q, count_n;
	logic [8:0]  dbs_q, dbs_n;
	logic [7:0]  hi_q, hi_n;
	logic [6:0]  ve_q, ve_n;

	// result queue, slot 0 is the head
	res_t        slot_q [2];
	res_t        slot_n [2];
	logic [1:0]  cnt_q, cnt_n;

	logic        adv, pop, hdr_ok, emit_val;
	logic [1:0]  n_res, base, free;
	logic [2:0]  verdict;
	res_t        val_res, ver_res, r0, r1;

	assign pop       = res_valid && res_ready;
	assign base      = cnt_q - {1'b0, pop};
	assign free      = 2'd2 - base;
	assign n_res     = {1'b0, emit_val} + {1'b0, req_s1.frame_end};
	assign adv       = v_s1 && (n_res <= free);
	assign req_ready = !v_s1 || adv;
	assign res_valid = (cnt_q != 2'd0);
	assign res       = slot_q[0];

	assign hdr_ok = (pos_q == POS_DATA) && code_ok_q &&
		(qty_q >= MIN_QTY) && (qty_q <= MAX_REGS) &&
		({qty_q, 1'b0} == {9'd0, count_q});

	always_comb begin
		pos_n     = pos_q;
		code_ok_n = code_ok_q;
		addr_n    = addr_q;
		qty_n     = qty_q;
		count_n   = count_q;
		dbs_n     = dbs_q;
		hi_n      = hi_q;
		ve_n      = ve_q;
		emit_val  = 1'b0;
		unique case (pos_q)
			POS_CODE: begin
				code_ok_n = (req_s1.data_byte == FUNC_CODE);
				pos_n     = POS_ADDR_HI;
			end
			POS_ADDR_HI: begin
				addr_n = {req_s1.data_byte, 8'd0};
				pos_n  = POS_ADDR_LO;
			end
			POS_ADDR_LO: begin
				addr_n = {addr_q[15:8], req_s1.data_byte};
				pos_n  = POS_QTY_HI;
			end
			POS_QTY_HI: begin
				qty_n = {req_s1.data_byte, 8'd0};
				pos_n = POS_QTY_LO;
			end
			POS_QTY_LO: begin
				qty_n = {qty_q[15:8], req_s1.data_byte};
				pos_n = POS_COUNT;
			end
			POS_COUNT: begin
				count_n = req_s1.data_byte;
				pos_n   = POS_DATA;
			end
			POS_DATA: begin
				// odd count means this is the low byte of a value
				if (dbs_q[0] && hdr_ok && ({9'd0, ve_q} < qty_q)) begin
					emit_val = 1'b1;
					ve_n     = ve_q + 7'd1;
				end else if (!dbs_q[0]) begin
					hi_n = req_s1.data_byte;
				end
				if (dbs_q != DATA_SAT)
					dbs_n = dbs_q + 9'd1;
			end
			default: ;
		endcase

		// verdict sees the state after this byte
		priority if (pos_n != POS_DATA)
			verdict = ST_SHORT;
		else if (!code_ok_n)
			verdict = ST_BAD_CODE;
		else if ((qty_n < MIN_QTY) || (qty_n > MAX_REGS))
			verdict = ST_BAD_QTY;
		else if ({qty_n, 1'b0} != {9'd0, count_n})
			verdict = ST_COUNT_ERR;
		else if (dbs_n != {1'b0, count_n})
			verdict = ST_LEN_ERR;
		else
			verdict = ST_OK;

		val_res = '{is_verdict: 1'b0, start_address: addr_q, value_index: ve_q,
			reg_value: {hi_q, req_s1.data_byte}, status: ST_OK,
			last_of_run: !req_s1.frame_end};
		ver_res = '{is_verdict: 1'b1, start_address: addr_n, value_index: 7'd0,
			reg_value: 16'd0, status: verdict, last_of_run: 1'b1};
		r0 = emit_val ? val_res : ver_res;
		r1 = ver_res;

		if (req_s1.frame_end) begin
			pos_n     = POS_CODE;
			code_ok_n = 1'b0;
			addr_n    = 16'd0;
			qty_n     = 16'd0;
			count_n   = 8'd0;
			dbs_n     = 9'd0;
			hi_n      = 8'd0;
			ve_n      = 7'd0;
		end
	end

	// queue update: shift out on pop, append new results behind what remains
	always_comb begin
		slot_n[0] = pop ? slot_q[1] : slot_q[0];
		slot_n[1] = slot_q[1];
		if (adv && (n_res != 2'd0)) begin
			if (base == 2'd0)
				slot_n[0] = r0;
			else
				slot_n[1] = r0;
			if (n_res == 2'd2)
				slot_n[1] = r1;
		end
		cnt_n = base + (adv ? n_res : 2'd0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (req_ready) begin
			v_s1 <= req_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req_ready && req_valid)
			req_s1 <= req;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q     <= POS_CODE;
			code_ok_q <= 1'b0;
			addr_q    <= 16'd0;
			qty_q     <= 16'd0;
			count_q   <= 8'd0;
			dbs_q     <= 9'd0;
			hi_q      <= 8'd0;
			ve_q      <= 7'd0;
		end else if (adv) begin
			pos_q     <= pos_n;
			code_ok_q <= code_ok_n;
			addr_q    <= addr_n;
			qty_q     <= qty_n;
			count_q   <= count_n;
			dbs_q     <= dbs_n;
			hi_q      <= hi_n;
			ve_q      <= ve_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
		end else begin
			cnt_q <= cnt_n;
		end
	end

	always_ff @(posedge clk) begin
		slot_q[0] <= slot_n[0];
		slot_q[1] <= slot_n[1];
	end

	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q != 2'd3)
		else $error("result queue count out of range");

	a_verdict_last: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res.is_verdict |-> res.last_of_run)
		else $error("verdict without last_of_run");

	a_value_status: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res.is_verdict |-> res.status == ST_OK)
		else $error("value result with nonzero status");

	a_frame_restart: assert property (@(posedge clk) disable iff (!arst_n)
		adv && req_s1.frame_end |=> pos_q == POS_CODE && dbs_q == 9'd0)
		else $error("parser did not return to header start after frame end");

endmodule
